// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on the clk / rst pair.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("HSV assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("HSV assertion failed");

`endif

// File: sv/hsv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Constants, sector codes and stage payload types of the converter pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int SECTOR_DEG   = 60;
  localparam int FULL_LEVEL   = 255;
  localparam int SECTOR_SPAN  = SECTOR_DEG * FULL_LEVEL;
  localparam int SECTOR_COUNT = 6;
  localparam int HUE_STEPS    = 511 / SECTOR_DEG;

  // Reciprocals for the divisions by 255 and by 15300 (round up, exact over
  // the operand ranges used here).
  localparam logic [15:0] RECIP_P = 16'd32897;
  localparam int          SHIFT_P = 23;
  localparam logic [22:0] RECIP_Q = 23'd4491470;
  localparam int          SHIFT_Q = 36;

  // Sector codes, named after the pair of primaries the hue runs between.
  localparam logic [2:0] SECTOR_RY = 3'd0;
  localparam logic [2:0] SECTOR_YG = 3'd1;
  localparam logic [2:0] SECTOR_GC = 3'd2;
  localparam logic [2:0] SECTOR_CB = 3'd3;
  localparam logic [2:0] SECTOR_BM = 3'd4;
  localparam logic [2:0] SECTOR_MR = 3'd5;

  typedef struct packed {
    logic [2:0] sector;
    logic [5:0] rem;
    logic [7:0] sat;
    logic [7:0] bri;
  } dec_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [7:0]  bri;
    logic [7:0]  ks;
    logic [13:0] sq;
    logic [13:0] st;
  } part_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [7:0]  bri;
    logic [15:0] pp;
    logic [21:0] pq;
    logic [21:0] pt;
  } prod_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [7:0] bri;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } lvl_t;

  // Number of whole 60-degree steps in a hue angle.
  function automatic logic [3:0] hue_step(input logic [8:0] h);
    logic [3:0] k;
    k = '0;
    for (int i = 1; i <= HUE_STEPS; i++) begin
      if (h >= 9'(i * SECTOR_DEG)) k = k + 4'd1;
    end
    return k;
  endfunction

endpackage

// File: sv/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one hue / saturation / value pixel into 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         hue, saturation, brightness
// m_axis    out        red, green, blue
//
// One request per clock is taken unless a stall on m_axis holds the pipeline;
// each result leaves through the output register (five register stages).
// The throughput is set by the pipeline, whose stages each hold one request.
// Reset clears all valid bits; payload registers are left as they are.
// A stall on m_axis holds the last stage, and earlier stages keep filling
// their empty slots until the pipeline is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // hue[8:0], saturation[16:9], brightness[24:17]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  logic  dec_valid;
  logic  dec_ready;
  dec_t  dec;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod;
  logic  lvl_valid;
  logic  lvl_ready;
  lvl_t  lvl;

  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  hsv_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .hue        (s_axis_tdata[8:0]),
    .saturation (s_axis_tdata[16:9]),
    .brightness (s_axis_tdata[24:17]),
    .out_valid  (dec_valid),
    .out_ready  (dec_ready),
    .out_data   (dec)
  );

  hsv_product u_product (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod)
  );

  hsv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_data  (lvl)
  );

  assign lvl_ready = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    case (lvl.sector)
      SECTOR_RY: begin
        red_next = lvl.bri; green_next = lvl.t;   blue_next = lvl.p;
      end
      SECTOR_YG: begin
        red_next = lvl.q;   green_next = lvl.bri; blue_next = lvl.p;
      end
      SECTOR_GC: begin
        red_next = lvl.p;   green_next = lvl.bri; blue_next = lvl.t;
      end
      SECTOR_CB: begin
        red_next = lvl.p;   green_next = lvl.q;   blue_next = lvl.bri;
      end
      SECTOR_BM: begin
        red_next = lvl.t;   green_next = lvl.p;   blue_next = lvl.bri;
      end
      SECTOR_MR: begin
        red_next = lvl.bri; green_next = lvl.p;   blue_next = lvl.q;
      end
      default: begin
        red_next = lvl.bri; green_next = lvl.p;   blue_next = lvl.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (lvl_ready) begin
      m_axis_tvalid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_ready && lvl_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_axis_tdata = {blue, green, red};

  // The decoded sector and remainder must stay inside one turn.
  `HSV_ASSERT_SAME(a_sector_range, dec_valid, dec.sector <= SECTOR_MR)
  `HSV_ASSERT_SAME(a_rem_range, dec_valid, dec.rem < 6'(SECTOR_DEG))
  // The rounded levels keep their order below the value.
  `HSV_ASSERT_SAME(a_level_order, lvl_valid,
    lvl.p <= lvl.q && lvl.p <= lvl.t && lvl.q <= lvl.bri && lvl.t <= lvl.bri)

endmodule

// File: sv/hsv_decode.sv
// ----------------------------------------------------------------------------
// HSV hue decode
// Splits the hue into its sector and the remainder within that sector.
// ----------------------------------------------------------------------------
module hsv_decode import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output dec_t       out_data
);

  logic [3:0] step;
  logic [8:0] base;
  dec_t       dec_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    step = hue_step(hue);
    base = 9'(step) * 9'(SECTOR_DEG);
    dec_next.rem = 6'(hue - base);
    // Hues past 359 wrap back into the first sectors.
    if (step >= 4'(SECTOR_COUNT)) begin
      dec_next.sector = 3'(step - 4'(SECTOR_COUNT));
    end else begin
      dec_next.sector = 3'(step);
    end
    dec_next.sat = saturation;
    dec_next.bri = brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= dec_next;
    end
  end

endmodule

// File: sv/hsv_product.sv
// ----------------------------------------------------------------------------
// HSV products
// Two stages: saturation terms, then the products with the value.
// ----------------------------------------------------------------------------
module hsv_product import hsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  dec_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_data
);

  logic       part_valid;
  logic       part_ready;
  part_t      part;
  part_t      part_next;
  prod_t      prod_next;
  logic [5:0] rem_up;
  logic [13:0] nq;
  logic [13:0] nt;

  assign part_ready = !out_valid || out_ready;
  assign in_ready   = !part_valid || part_ready;

  always_comb begin
    rem_up            = 6'(SECTOR_DEG) - in_data.rem;
    part_next.sector  = in_data.sector;
    part_next.bri     = in_data.bri;
    part_next.ks      = 8'(FULL_LEVEL) - in_data.sat;
    part_next.sq      = 14'(in_data.sat) * 14'(in_data.rem);
    part_next.st      = 14'(in_data.sat) * 14'(rem_up);
  end

  always_comb begin
    nq               = 14'(SECTOR_SPAN) - part.sq;
    nt               = 14'(SECTOR_SPAN) - part.st;
    prod_next.sector = part.sector;
    prod_next.bri    = part.bri;
    prod_next.pp     = 16'(part.bri) * 16'(part.ks);
    prod_next.pq     = 22'(part.bri) * 22'(nq);
    prod_next.pt     = 22'(part.bri) * 22'(nt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) part_valid <= in_valid;
      if (part_ready) out_valid <= part_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      part <= part_next;
    end
    if (part_ready && part_valid) begin
      out_data <= prod_next;
    end
  end

endmodule

// File: sv/hsv_scale.sv
// ----------------------------------------------------------------------------
// HSV scale
// Rounds the products back to 8-bit levels p, q and t.
// ----------------------------------------------------------------------------
module hsv_scale import hsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output lvl_t  out_data
);

  logic [15:0] xp;
  logic [21:0] yq;
  logic [21:0] yt;
  logic [31:0] mp;
  logic [44:0] mq;
  logic [44:0] mt;
  lvl_t        lvl_next;

  assign in_ready = !out_valid || out_ready;

  // Rounding half up: floor((x + d/2) / d), the division done by reciprocal.
  always_comb begin
    xp = in_data.pp + 16'(FULL_LEVEL / 2);
    yq = in_data.pq + 22'(SECTOR_SPAN / 2);
    yt = in_data.pt + 22'(SECTOR_SPAN / 2);
    mp = 32'(xp) * 32'(RECIP_P);
    mq = 45'(yq) * 45'(RECIP_Q);
    mt = 45'(yt) * 45'(RECIP_Q);
    lvl_next.sector = in_data.sector;
    lvl_next.bri    = in_data.bri;
    lvl_next.p      = mp[SHIFT_P +: 8];
    lvl_next.q      = mq[SHIFT_Q +: 8];
    lvl_next.t      = mt[SHIFT_Q +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= lvl_next;
    end
  end

endmodule
